// ----- rtl/core/sdk_pkg.sv -----
// ============================================================================
// sdk_pkg
// Shared types, constants and the arctangent table of the wheel kinematics.
// ============================================================================
package sdk_pkg;

    localparam int CordicIterationsDef = 16;
    localparam int CordicIterationsMax = 24;
    localparam int HalfPiQ = 6434;
    localparam int SpeedMax = 16383;
    localparam int SpeedMin = -16384;
    localparam int ZW = 33;

    typedef enum logic [1:0] {
        MODE_STOP = 2'd0,
        MODE_STRAFE = 2'd1,
        MODE_CIRCULAR = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        REG_LENGTH = 2'd0,
        REG_WIDTH = 2'd1,
        REG_THRESHOLD = 2'd2
    } reg_index_t;

    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] r;
        begin
            case (i)
                5'd0: r = 32'h3243F6A8;
                5'd1: r = 32'h1DAC6705;
                5'd2: r = 32'h0FADBAFC;
                5'd3: r = 32'h07F56EA6;
                5'd4: r = 32'h03FEAB76;
                5'd5: r = 32'h01FFD55B;
                5'd6: r = 32'h00FFFAAA;
                5'd7: r = 32'h007FFF55;
                5'd8: r = 32'h003FFFEA;
                5'd9: r = 32'h001FFFFD;
                5'd10: r = 32'h000FFFFF;
                5'd11: r = 32'h0007FFFF;
                5'd12: r = 32'h0003FFFF;
                5'd13: r = 32'h0001FFFF;
                5'd14: r = 32'h0000FFFF;
                5'd15: r = 32'h00007FFF;
                5'd16: r = 32'h00003FFF;
                5'd17: r = 32'h00001FFF;
                5'd18: r = 32'h00000FFF;
                5'd19: r = 32'h000007FF;
                5'd20: r = 32'h000003FF;
                5'd21: r = 32'h000001FF;
                5'd22: r = 32'h000000FF;
                5'd23: r = 32'h0000007F;
                default: r = 32'h0;
            endcase
            return r;
        end
    endfunction

endpackage

// ----- rtl/core/sdk_atan_pipe.sv -----
// ============================================================================
// sdk_atan_pipe
// Pipelined arctangent of a nonnegative ratio y/x, one CORDIC step a stage.
// ============================================================================
module sdk_atan_pipe
    import sdk_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = CordicIterationsDef
)
(
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] x_in,
    input  logic [31:0] y_in,
    output logic [12:0] angle
);

    localparam int N = CORDIC_ITERATIONS;

    logic signed [33:0] x_reg [N+1];
    logic signed [33:0] y_reg [N+1];
    logic signed [ZW-1:0] z_reg [N+1];
    logic [1:0] spec_reg [N+1];

    logic [31:0] x_norm_next;
    logic [31:0] y_norm_next;
    logic [4:0] shift_c;
    logic [31:0] ormask;

    always_comb
    begin
        ormask = x_in | y_in;
        shift_c = 5'd0;
        for (int b = 0; b < 31; b++)
        begin
            if (ormask[b])
            begin
                shift_c = 5'(30 - b);
            end
        end
        if (ormask[31] || ormask[30])
        begin
            shift_c = 5'd0;
        end
        x_norm_next = x_in << shift_c;
        y_norm_next = y_in << shift_c;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= {2'b00, x_norm_next};
            y_reg[0] <= {2'b00, y_norm_next};
            z_reg[0] <= '0;
            spec_reg[0] <= (y_in == 32'd0) ? 2'd1 : ((x_in == 32'd0) ? 2'd2 : 2'd0);
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                spec_reg[i+1] <= spec_reg[i];
                if (!y_reg[i][33])
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + $signed({1'b0, atan_entry(5'(i))});
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - $signed({1'b0, atan_entry(5'(i))});
                end
            end
        end
    end

    logic signed [ZW-1:0] zr;
    always_comb
    begin
        zr = (z_reg[N] + ZW'(1 << 17)) >>> 18;
        if (spec_reg[N] == 2'd1 || z_reg[N] <= 0)
        begin
            angle = 13'd0;
        end
        else if (spec_reg[N] == 2'd2 || zr > ZW'(HalfPiQ))
        begin
            angle = 13'(HalfPiQ);
        end
        else
        begin
            angle = zr[12:0];
        end
    end

endmodule

// ----- rtl/core/sdk_sqrt_pipe.sv -----
// ============================================================================
// sdk_sqrt_pipe
// Pipelined integer square root, one result bit a stage, floor and remainder.
// ============================================================================
module sdk_sqrt_pipe
(
    input  logic        clk,
    input  logic        en,
    input  logic [55:0] s_in,
    output logic [27:0] root,
    output logic [28:0] rem
);

    localparam int B = 28;

    logic [57:0] s_reg [B+1];
    logic [57:0] r_reg [B+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg[0] <= {2'b00, s_in};
            r_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < B; k++)
    begin : g_bit
        localparam logic [57:0] BIT = 58'd1 << (2 * (B - 1 - k));
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (s_reg[k] >= r_reg[k] + BIT)
                begin
                    s_reg[k+1] <= s_reg[k] - (r_reg[k] + BIT);
                    r_reg[k+1] <= (r_reg[k] >> 1) + BIT;
                end
                else
                begin
                    s_reg[k+1] <= s_reg[k];
                    r_reg[k+1] <= r_reg[k] >> 1;
                end
            end
        end
    end

    assign root = r_reg[B][27:0];
    assign rem = s_reg[B][28:0];

endmodule

// ----- rtl/core/swerve_drive_kinematics.sv -----
// ============================================================================
// swerve_drive_kinematics
// Body velocity command to steering angles and speeds of four wheels.
// ============================================================================
// A command request enters on s_axis: tdata holds cmd_forward [13:0],
// cmd_sideways [27:14] and cmd_turn_rate [41:28]. Each command gives one
// result request on m_axis: tdata holds the four angles (FR, FL, BR, BL),
// then the four speeds in the same order, 15 bits each, from bit 0 up,
// and motion_mode in bits [121:120].
// The pipeline takes one command every cycle unless stalled. A result is
// registered through the product stage, the 29 square root registers and
// the output register. The CORDIC units have CORDIC_ITERATIONS + 1
// stages and their angles are delayed to match. All stages advance
// together; when m_axis_tready is low and the output holds a result,
// the whole pipeline stalls and nothing is lost. Reset clears the valid
// bits and loads the register defaults. The configuration port writes
// one register per cycle; users must write while idle (not enforced).
// ============================================================================
module swerve_drive_kinematics
    import sdk_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = CordicIterationsDef
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [47:0]  s_axis_tdata,  // cmd_forward, cmd_sideways, cmd_turn_rate
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,  // angles FR FL BR BL, speeds, motion_mode
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [12:0]  cfg_data
);

    localparam int LA = CORDIC_ITERATIONS + 1;
    localparam int LS = 29;
    localparam int LAT = (LA > LS ? LA : LS) + 2;

    logic [12:0] len_reg;
    logic [12:0] wid_reg;
    logic [9:0] thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= 13'd256;
            wid_reg <= 13'd256;
            thr_reg <= 10'd10;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LENGTH: len_reg <= cfg_data;
                REG_WIDTH: wid_reg <= cfg_data;
                REG_THRESHOLD: thr_reg <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic [LAT-1:0] vld_reg;
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
        end
    end

    // Stage 1: products.
    logic signed [13:0] x_c, y_c, w_c;
    assign x_c = s_axis_tdata[13:0];
    assign y_c = s_axis_tdata[27:14];
    assign w_c = s_axis_tdata[41:28];

    logic signed [27:0] d_reg, nl_reg, nr_reg;
    logic signed [13:0] x1_reg, y1_reg, w1_reg;
    logic circ1_reg;
    logic signed [13:0] wabs_c;
    logic [12:0] len_c;

    always_comb
    begin
        wabs_c = w_c[13] ? -w_c : w_c;
        len_c = (len_reg == 13'd0) ? 13'd1 : len_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= $signed({1'b0, len_c}) * w_c;
            nl_reg <= ($signed(x_c) <<< 10) - $signed({1'b0, wid_reg}) * w_c;
            nr_reg <= ($signed(x_c) <<< 10) + $signed({1'b0, wid_reg}) * w_c;
            x1_reg <= x_c;
            y1_reg <= y_c;
            w1_reg <= w_c;
            circ1_reg <= ({1'b0, wabs_c[12:0]} > {4'b0, thr_reg}) || (w_c == -14'sd8192);
        end
    end

    // Stage 2 operands: absolute values for both units.
    logic [27:0] dabs, nlabs, nrabs, xabs, yabs;
    logic [27:0] la_y, ra_y, la_x;
    logic l_neg, r_neg;
    logic [55:0] sl_c, sr_c;

    always_comb
    begin
        dabs = d_reg[27] ? 28'(-d_reg) : 28'(d_reg);
        nlabs = nl_reg[27] ? 28'(-nl_reg) : 28'(nl_reg);
        nrabs = nr_reg[27] ? 28'(-nr_reg) : 28'(nr_reg);
        xabs = x1_reg[13] ? 28'(-x1_reg) : 28'(x1_reg);
        yabs = y1_reg[13] ? 28'(-y1_reg) : 28'(y1_reg);
        if (circ1_reg)
        begin
            la_x = dabs;
            la_y = nlabs;
            ra_y = nrabs;
            l_neg = nl_reg[27] ^ d_reg[27];
            r_neg = nr_reg[27] ^ d_reg[27];
            sl_c = nlabs * nlabs + dabs * dabs;
            sr_c = nrabs * nrabs + dabs * dabs;
        end
        else
        begin
            la_x = xabs;
            la_y = yabs;
            ra_y = yabs;
            l_neg = y1_reg[13] ^ x1_reg[13];
            r_neg = l_neg;
            sl_c = xabs * xabs + yabs * yabs;
            sr_c = sl_c;
        end
    end

    logic [12:0] al_u, ar_u;
    logic [27:0] rl_u, rr_u;
    logic [28:0] reml_u, remr_u;

    sdk_atan_pipe #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_atan_l (
        .clk(clk), .en(en), .x_in({4'b0, la_x}), .y_in({4'b0, la_y}), .angle(al_u));
    sdk_atan_pipe #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_atan_r (
        .clk(clk), .en(en), .x_in({4'b0, la_x}), .y_in({4'b0, ra_y}), .angle(ar_u));
    sdk_sqrt_pipe u_sqrt_l (.clk(clk), .en(en), .s_in(sl_c), .root(rl_u), .rem(reml_u));
    sdk_sqrt_pipe u_sqrt_r (.clk(clk), .en(en), .s_in(sr_c), .root(rr_u), .rem(remr_u));

    // Side information delayed to line up with the units.
    typedef struct packed {
        logic circ;
        logic strafe;
        logic l_neg;
        logic r_neg;
        logic x_neg;
        logic x_zero;
        logic w_neg;
    } side_t;

    side_t side_c;
    always_comb
    begin
        side_c.circ = circ1_reg;
        side_c.strafe = (x1_reg != 0) || (y1_reg != 0);
        side_c.l_neg = l_neg;
        side_c.r_neg = r_neg;
        side_c.x_neg = x1_reg[13];
        side_c.x_zero = (x1_reg == 0);
        side_c.w_neg = w1_reg[13];
    end

    side_t side_reg [LS];
    logic [12:0] al_reg [LS];
    logic [12:0] ar_reg [LS];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_c;
            for (int k = 0; k < LS - 1; k++)
            begin
                side_reg[k+1] <= side_reg[k];
            end
            al_reg[LA] <= al_u;
            ar_reg[LA] <= ar_u;
            for (int k = LA; k < LS - 1; k++)
            begin
                al_reg[k+1] <= al_reg[k];
                ar_reg[k+1] <= ar_reg[k];
            end
        end
    end

    // The angles are delayed by the difference in depth to match the roots.
    logic [12:0] al_f, ar_f;
    side_t sd;
    assign al_f = (LA >= LS) ? al_u : al_reg[LS-1];
    assign ar_f = (LA >= LS) ? ar_u : ar_reg[LS-1];
    assign sd = side_reg[LS - 1];

    // Final stage: signs, speeds and saturation.
    logic signed [14:0] aL, aR, angL, angR, ang_s;
    logic signed [29:0] ml, mr, vl, vr, sv;
    logic [28:0] rs;
    logic signed [1:0] dir, sp;
    logic [119:0] pay_c;
    mode_t mode_c;

    function automatic logic signed [14:0] sat15(input logic signed [29:0] v);
        begin
            if (v > 30'sd16383)
            begin
                return 15'sd16383;
            end
            else if (v < -30'sd16384)
            begin
                return -15'sd16384;
            end
            return v[14:0];
        end
    endfunction

    always_comb
    begin
        aL = sd.l_neg ? -$signed({2'b0, al_f}) : $signed({2'b0, al_f});
        aR = sd.r_neg ? -$signed({2'b0, ar_f}) : $signed({2'b0, ar_f});
        angL = 15'(HalfPiQ) - aL;
        angR = 15'(HalfPiQ) - aR;
        dir = sd.x_zero ? (sd.w_neg ? 2'sd1 : -2'sd1) : (sd.x_neg ? -2'sd1 : 2'sd1);
        sp = sd.x_zero ? 2'sd0 : ((sd.x_neg ^ sd.w_neg) ? -2'sd1 : 2'sd1);
        ml = 30'(({2'b0, rl_u} + 30'd512) >> 10);
        mr = 30'(({2'b0, rr_u} + 30'd512) >> 10);
        vl = (dir < 0) ? -ml : ml;
        vr = (dir < 0) ? -mr : mr;
        if (angL >= 15'(HalfPiQ) && sp > 0)
        begin
            vl = -vl;
        end
        if (angR <= 15'(HalfPiQ) && sp <= 0)
        begin
            vr = -vr;
        end
        rs = {1'b0, rl_u} + ((reml_u > {1'b0, rl_u}) ? 29'd1 : 29'd0);
        sv = sd.x_neg ? -$signed({1'b0, rs}) : $signed({1'b0, rs});
        ang_s = -aL;
        pay_c = '0;
        mode_c = MODE_STOP;
        if (sd.circ)
        begin
            mode_c = MODE_CIRCULAR;
            pay_c = {sat15(vl), sat15(vr), sat15(vl), sat15(vr),
                     angL, angR, -angL, -angR};
        end
        else if (sd.strafe)
        begin
            mode_c = MODE_STRAFE;
            pay_c = {sat15(sv), sat15(sv), sat15(sv), sat15(sv),
                     ang_s, ang_s, ang_s, ang_s};
        end
    end

    logic [127:0] out_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= {6'b0, mode_c, pay_c};
        end
    end
    assign m_axis_tdata = out_reg;

endmodule

// ----- rtl/core/sdk_checker.sv -----
// ============================================================================
// sdk_checker
// Port-level checks of the kinematics block, bound to the top level.
// ============================================================================
module sdk_checker
    import sdk_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_mode: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[121:120] <= MODE_CIRCULAR)
        else $error("bad motion mode");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

    a_stop: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[121:120] == MODE_STOP |-> m_axis_tdata[119:0] == 120'd0)
        else $error("stop result not zero");

endmodule

bind swerve_drive_kinematics sdk_checker u_sdk_checker (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata));

// ----- verif/swerve_drive_kinematics_tb.sv -----
// ============================================================================
// swerve_drive_kinematics_tb
// Self-checking bench for the wheel kinematics pipeline.
// Random and directed command requests are sent with random gaps, and
// results are taken with random back pressure. A scoreboard class predicts
// each result from the command and the current register settings, and
// compares every field of each result in order.
// ============================================================================
module swerve_drive_kinematics_tb
    import sdk_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  mode;
        logic [14:0] spd_bl;
        logic [14:0] spd_br;
        logic [14:0] spd_fl;
        logic [14:0] spd_fr;
        logic [14:0] ang_bl;
        logic [14:0] ang_br;
        logic [14:0] ang_fl;
        logic [14:0] ang_fr;
    } wheel_set_t;

    class kinematics_scoreboard;
        wheel_set_t pending[$];
        longint len_q = 256;
        longint wid_q = 256;
        longint thr_q = 10;
        int errors = 0;

        function void set_reg(reg_index_t idx, logic [12:0] v);
            case (idx)
                REG_LENGTH: len_q = v;
                REG_WIDTH: wid_q = v;
                REG_THRESHOLD: thr_q = v[9:0];
                default: ;
            endcase
        endfunction

        function longint shr_fl(longint v, int s);
            if (v >= 0)
                return v >>> s;
            return -((-v - 1) >>> s) - 1;
        endfunction

        function longint atan_q(longint x, longint y);
            longint z;
            longint xs;
            longint ys;
            z = 0;
            if (y == 0)
                return 0;
            if (x == 0)
                return HalfPiQ;
            while (x < (64'sd1 << 30) && y < (64'sd1 << 30))
            begin
                x = x * 2;
                y = y * 2;
            end
            for (int i = 0; i < CordicIterationsDef; i++)
            begin
                xs = shr_fl(x, i);
                ys = shr_fl(y, i);
                if (y >= 0)
                begin
                    x = x + ys;
                    y = y - xs;
                    z = z + longint'(atan_entry(i[4:0]));
                end
                else
                begin
                    x = x - ys;
                    y = y + xs;
                    z = z - longint'(atan_entry(i[4:0]));
                end
            end
            if (z <= 0)
                return 0;
            z = (z + (64'sd1 << 17)) >>> 18;
            return z > HalfPiQ ? HalfPiQ : z;
        endfunction

        function longint signed_atan(longint n, longint d);
            if (d < 0)
            begin
                d = -d;
                n = -n;
            end
            if (n < 0)
                return -atan_q(d, -n);
            return atan_q(d, n);
        endfunction

        function longint root_floor(longint unsigned s);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > s)
                b = b >> 2;
            while (b != 0)
            begin
                if (s >= r + b)
                begin
                    s = s - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return longint'(r);
        endfunction

        function longint clip(longint v);
            if (v > SpeedMax)
                return SpeedMax;
            if (v < SpeedMin)
                return SpeedMin;
            return v;
        endfunction

        function int sg(longint v);
            return (v > 0) - (v < 0);
        endfunction

        function void note_command(logic [41:0] cmd);
            wheel_set_t e;
            longint x, y, w, len, d, nl, nr, al, ar, ml, mr, vl, vr, r, ang, px, py;
            longint unsigned sq;
            int dir, sp;
            x = longint'(signed'(cmd[13:0]));
            y = longint'(signed'(cmd[27:14]));
            w = longint'(signed'(cmd[41:28]));
            e = '0;
            if ((w < 0 ? -w : w) > thr_q)
            begin
                len = len_q == 0 ? 1 : len_q;
                d = len * w;
                nl = 1024 * x - wid_q * w;
                nr = 1024 * x + wid_q * w;
                al = HalfPiQ - signed_atan(nl, d);
                ar = HalfPiQ - signed_atan(nr, d);
                dir = x != 0 ? sg(x) : -sg(w);
                sp = sg(w) * sg(x);
                ml = (root_floor(nl * nl + d * d) + 512) >>> 10;
                mr = (root_floor(nr * nr + d * d) + 512) >>> 10;
                vl = dir * ml;
                vr = dir * mr;
                if (al >= HalfPiQ && sp > 0)
                    vl = -vl;
                if (ar <= HalfPiQ && sp <= 0)
                    vr = -vr;
                vl = clip(vl);
                vr = clip(vr);
                e.ang_fr = 15'(-ar);
                e.ang_fl = 15'(-al);
                e.ang_br = 15'(ar);
                e.ang_bl = 15'(al);
                e.spd_fr = 15'(vr);
                e.spd_br = 15'(vr);
                e.spd_fl = 15'(vl);
                e.spd_bl = 15'(vl);
                e.mode = MODE_CIRCULAR;
            end
            else if (x != 0 || y != 0)
            begin
                sq = x * x + y * y;
                r = root_floor(sq);
                if (sq - r * r > r)
                    r++;
                px = x;
                py = y;
                if (x < 0)
                begin
                    px = -x;
                    py = -y;
                    r = -r;
                end
                ang = -signed_atan(py, px);
                r = clip(r);
                e.ang_fr = 15'(ang);
                e.ang_fl = 15'(ang);
                e.ang_br = 15'(ang);
                e.ang_bl = 15'(ang);
                e.spd_fr = 15'(r);
                e.spd_fl = 15'(r);
                e.spd_br = 15'(r);
                e.spd_bl = 15'(r);
                e.mode = MODE_STRAFE;
            end
            else
                e.mode = MODE_STOP;
            pending.insert(pending.size(), e);
        endfunction

        function void check_field(string name, logic [14:0] exp_v, logic [14:0] act_v);
            if (exp_v !== act_v)
            begin
                $error("%s expected %0d actual %0d", name, signed'(exp_v), signed'(act_v));
                errors++;
            end
        endfunction

        function void check_result(logic [127:0] data);
            wheel_set_t e;
            wheel_set_t a;
            a = data[121:0];
            if (pending.size() == 0)
            begin
                $error("unexpected result request %h", data);
                errors++;
                return;
            end
            e = pending.pop_front();
            check_field("angle_front_right", e.ang_fr, a.ang_fr);
            check_field("angle_front_left", e.ang_fl, a.ang_fl);
            check_field("angle_back_right", e.ang_br, a.ang_br);
            check_field("angle_back_left", e.ang_bl, a.ang_bl);
            check_field("speed_front_right", e.spd_fr, a.spd_fr);
            check_field("speed_front_left", e.spd_fl, a.spd_fl);
            check_field("speed_back_right", e.spd_br, a.spd_br);
            check_field("speed_back_left", e.spd_bl, a.spd_bl);
            check_field("motion_mode", 15'(e.mode), 15'(a.mode));
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [47:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [12:0]  cfg_data;
    longint       cycles;
    kinematics_scoreboard sb;

    swerve_drive_kinematics u_top (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45)
            return 0;
        if (p < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic idle_cycles(int n);
        repeat (n) @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [12:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, v);
        @(posedge clk);
    endtask

    task automatic send_command(logic [13:0] x, logic [13:0] y, logic [13:0] w);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            s_axis_tvalid <= 1'b0;
            idle_cycles(g);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, w, y, x};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_command({w, y, x});
    endtask

    task automatic finish_burst();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        idle_cycles(CordicIterationsDef + 40);
    endtask

    function automatic logic [13:0] rand_cmd();
        int p;
        p = $urandom_range(0, 9);
        if (p == 0)
            return 14'd0;
        if (p < 3)
            return 14'($urandom_range(0, 40)) - 14'd20;
        return 14'($urandom);
    endfunction

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_LENGTH;
        cfg_data = '0;
        idle_cycles(10);
        rst_n <= 1'b1;
        idle_cycles(2);

        send_command(14'd0, 14'd0, 14'd0);
        send_command(14'h1FFF, 14'd0, 14'd0);
        send_command(14'h2000, 14'd0, 14'd0);
        send_command(14'd0, 14'h1FFF, 14'd0);
        send_command(14'd0, 14'h2000, 14'd0);
        send_command(14'h2000, 14'h2000, 14'd0);
        send_command(14'h1FFF, 14'h1FFF, 14'd10);
        send_command(14'h3FFF, 14'd5, 14'h3FF6);
        send_command(14'd0, 14'd0, 14'd11);
        send_command(14'd0, 14'd0, 14'h3FF5);
        send_command(14'h1FFF, 14'h2000, 14'h1FFF);
        send_command(14'h2000, 14'h1FFF, 14'h2000);
        send_command(14'd100, 14'd0, 14'd400);
        send_command(14'h3F9C, 14'd0, 14'd400);
        send_command(14'd100, 14'd0, 14'h3E70);
        send_command(14'd256, 14'd0, 14'd1024);
        send_command(14'd300, 14'd0, 14'h3C00);
        finish_burst();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(REG_LENGTH, 13'd0);
                    write_reg(REG_WIDTH, 13'd0);
                    write_reg(REG_THRESHOLD, 13'd0);
                end
                1:
                begin
                    write_reg(REG_LENGTH, 13'h1FFF);
                    write_reg(REG_WIDTH, 13'h1FFF);
                    write_reg(REG_THRESHOLD, 13'd1023);
                end
                2:
                begin
                    write_reg(REG_LENGTH, 13'd1);
                    write_reg(REG_WIDTH, 13'd4096);
                    write_reg(REG_THRESHOLD, 13'd1);
                end
                3:
                begin
                    write_reg(REG_LENGTH, 13'd4096);
                    write_reg(REG_WIDTH, 13'd1);
                    write_reg(REG_THRESHOLD, 13'd500);
                end
                default:
                begin
                    write_reg(REG_LENGTH, 13'($urandom_range(1, 4096)));
                    write_reg(REG_WIDTH, 13'($urandom_range(0, 4096)));
                    write_reg(REG_THRESHOLD, 13'($urandom_range(0, 1023)));
                end
            endcase
            for (int i = 0; i < 140; i++)
                send_command(rand_cmd(), rand_cmd(), rand_cmd());
            finish_burst();
        end

        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            if ($urandom_range(0, 3) == 0)
                m_axis_tready <= 1'b1;
            else if ($urandom_range(0, 2) == 0)
                m_axis_tready <= 1'b0;
            else
                m_axis_tready <= (gap_len() == 0);
        end
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 400000)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

endmodule
